@@ rtl/pc_function_trace_buffer_macros.svh @@
// Assertion macros for the function trace buffer checker.
// No dependencies.
`ifndef PC_FUNCTION_TRACE_BUFFER_MACROS_SVH
`define PC_FUNCTION_TRACE_BUFFER_MACROS_SVH

// a implies b in the same cycle
`define PCFTB_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("pcftb check failed");

// a implies b in the next cycle
`define PCFTB_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("pcftb check failed");

`endif

@@ rtl/pcftb_pkg.sv @@
// Shared types and codes for the function trace buffer.
// No dependencies.
package pcftb_pkg;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_RECORD = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic [3:0] TYPE_MASK = 4'hF;
    localparam logic [3:0] TYPE_FUNC = 4'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RING_RD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [7:0]  hit_index;
        logic [31:0] hit_start;
        logic        pushed;
        logic [31:0] trace_start;
        logic [7:0]  trace_index;
    } result_t;

endpackage

@@ rtl/pcftb_ram.sv @@
// Single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module pcftb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pc_function_trace_buffer.sv @@
// Top level of the function trace buffer: control, range table and trace ring.
// Depends on pcftb_pkg and pcftb_ram.
//
// A load goes straight to its result, and a read reads the ring first unless
// the offset lies past the held entries. A record scans the table entries in
// order until the first match (all loaded entries when nothing matches, none
// for an empty table). The scan reads the range table one entry per cycle
// through its single read port. Results sit in an output register, so the next
// request is taken while a result still waits. No clearing pass.
module pc_function_trace_buffer
    import pcftb_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int RING_DEPTH  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [31:0] sym_start,
    input  logic [31:0] sym_length,
    input  logic [7:0]  sym_info,
    input  logic [31:0] pc,
    input  logic [5:0]  read_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        hit,
    output logic [7:0]  hit_index,
    output logic [31:0] hit_start,
    output logic        pushed,
    output logic [31:0] trace_start,
    output logic [7:0]  trace_index,
    output logic [5:0]  trace_fill
);

    localparam int TW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = $clog2(RING_DEPTH);
    localparam int OW = (RW > 6) ? RW : 6;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [TW-1:0]   last_idx_reg, last_idx_next;
    logic            last_valid_reg, last_valid_next;
    logic [RW-1:0]   head_reg, head_next;
    logic [RW-1:0]   tail_reg, tail_next;
    logic [TW-1:0]   chk_idx_reg, chk_idx_next;
    logic [31:0]     pc_reg, pc_next;
    result_t         res_reg, res_next;
    result_t         out_reg, out_next;
    logic [5:0]      fill_reg, fill_next;
    logic            out_valid_reg, out_valid_next;

    logic            tab_we, tab_re;
    logic [TW-1:0]   tab_waddr, tab_raddr;
    logic [63:0]     tab_rdata;
    logic            ring_we, ring_re;
    logic [RW-1:0]   ring_raddr;
    logic [39:0]     ring_wdata, ring_rdata;

    logic            accept, out_free;
    logic            is_func, tab_full;
    logic [31:0]     lo, hi;
    logic            scan_hit, scan_last, push;
    logic [CW-1:0]   chk_cnt;
    logic [TW+7:0]   idx_wide;
    logic [7:0]      idx8;
    logic [RW:0]     held_sum, held_adj, slot_sum, slot_adj;
    logic [RW-1:0]   held, slot;
    logic [OW-1:0]   offs_ext, held_ext;
    logic            in_range;
    logic [RW+5:0]   fill_wide;
    logic [RW-1:0]   tail_inc, head_inc;

    pcftb_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata ({sym_start, sym_length}),
        .re    (tab_re),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    pcftb_ram #(.WIDTH(40), .DEPTH(RING_DEPTH)) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (tail_reg),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign is_func  = (sym_info[3:0] & TYPE_MASK) == TYPE_FUNC;
    assign tab_full = count_reg == CW'(TABLE_DEPTH);

    assign lo        = tab_rdata[63:32];
    assign hi        = lo + tab_rdata[31:0];
    assign scan_hit  = (pc_reg >= lo) && (pc_reg < hi);
    assign chk_cnt   = CW'(chk_idx_reg) + CW'(1);
    assign scan_last = chk_cnt == count_reg;
    assign idx_wide  = {8'b0, chk_idx_reg};
    assign idx8      = idx_wide[7:0];
    assign push      = scan_hit && (!last_valid_reg || last_idx_reg != chk_idx_reg);
    assign ring_wdata = {lo, idx8};

    assign held_sum = {1'b0, tail_reg} + (RW+1)'(RING_DEPTH) - {1'b0, head_reg};
    assign held_adj = (held_sum >= (RW+1)'(RING_DEPTH)) ? held_sum - (RW+1)'(RING_DEPTH)
                                                      : held_sum;
    assign held     = held_adj[RW-1:0];
    assign offs_ext = OW'(read_offset);
    assign held_ext = OW'(held);
    assign in_range = offs_ext < held_ext;
    assign slot_sum = {1'b0, head_reg} + {1'b0, offs_ext[RW-1:0]};
    assign slot_adj = (slot_sum >= (RW+1)'(RING_DEPTH)) ? slot_sum - (RW+1)'(RING_DEPTH)
                                                      : slot_sum;
    assign slot     = slot_adj[RW-1:0];
    assign fill_wide = {6'b0, held};

    assign tail_inc = (tail_reg == RW'(RING_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_inc = (head_reg == RW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_RECORD && count_reg != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (func == FUNC_READ && in_range)
                    begin
                        state_next = ST_RING_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RING_RD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory controls and handshake
    always_comb
    begin
        in_ready   = 1'b0;
        tab_we     = 1'b0;
        tab_waddr  = count_reg[TW-1:0];
        tab_re     = 1'b0;
        tab_raddr  = '0;
        ring_we    = 1'b0;
        ring_re    = 1'b0;
        ring_raddr = slot;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                tab_we   = in_valid && func == FUNC_LOAD && is_func && !tab_full;
                tab_re   = in_valid && func == FUNC_RECORD;
                ring_re  = in_valid && func == FUNC_READ && in_range;
            end
            ST_SCAN:
            begin
                tab_re    = !scan_hit && !scan_last;
                tab_raddr = chk_idx_reg + 1'b1;
                ring_we   = push;
            end
            default:
            begin
            end
        endcase
    end

    // datapath
    always_comb
    begin
        count_next      = count_reg;
        last_idx_next   = last_idx_reg;
        last_valid_next = last_valid_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        chk_idx_next    = chk_idx_reg;
        pc_next         = pc_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        fill_next       = fill_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next     = '0;
                    pc_next      = pc;
                    chk_idx_next = '0;
                    if (func == FUNC_LOAD && is_func)
                    begin
                        if (tab_full)
                        begin
                            res_next.status = STAT_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    if (func == FUNC_READ && !in_range)
                    begin
                        res_next.status = STAT_RANGE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    res_next.hit       = 1'b1;
                    res_next.hit_index = idx8;
                    res_next.hit_start = lo;
                    if (push)
                    begin
                        res_next.pushed = 1'b1;
                        last_valid_next = 1'b1;
                        last_idx_next   = chk_idx_reg;
                        tail_next       = tail_inc;
                        if (tail_inc == head_reg)
                        begin
                            head_next = head_inc;
                        end
                    end
                end
                else if (!scan_last)
                begin
                    chk_idx_next = chk_idx_reg + 1'b1;
                end
            end
            ST_RING_RD:
            begin
                res_next.trace_start = ring_rdata[39:8];
                res_next.trace_index = ring_rdata[7:0];
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    fill_next      = fill_wide[5:0];
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            last_idx_reg   <= '0;
            last_valid_reg <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            last_idx_reg   <= last_idx_next;
            last_valid_reg <= last_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        pc_reg      <= pc_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
        fill_reg    <= fill_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign hit         = out_reg.hit;
    assign hit_index   = out_reg.hit_index;
    assign hit_start   = out_reg.hit_start;
    assign pushed      = out_reg.pushed;
    assign trace_start = out_reg.trace_start;
    assign trace_index = out_reg.trace_index;
    assign trace_fill  = fill_reg;

endmodule

@@ rtl/pcftb_checker.sv @@
// Port-level checks for the function trace buffer, bound to the top level.
// Depends on pcftb_pkg and pc_function_trace_buffer_macros.svh.
`include "pc_function_trace_buffer_macros.svh"

module pcftb_checker
    import pcftb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic        hit,
    input  logic [7:0]  hit_index,
    input  logic [31:0] hit_start,
    input  logic        pushed,
    input  logic [31:0] trace_start,
    input  logic [7:0]  trace_index
);

    `PCFTB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(hit_start) && $stable(trace_start))
    `PCFTB_ASSERT_IMPLY(a_no_hit_zero, clk, rst_n, out_valid && !hit, hit_index == 8'd0 && hit_start == 32'd0 && !pushed)
    `PCFTB_ASSERT_IMPLY(a_status_code, clk, rst_n, out_valid, status == STAT_OK || status == STAT_FULL || status == STAT_RANGE)
    `PCFTB_ASSERT_IMPLY(a_range_zero, clk, rst_n, out_valid && status == STAT_RANGE, trace_start == 32'd0 && trace_index == 8'd0 && !hit)

endmodule

bind pc_function_trace_buffer pcftb_checker u_pcftb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .hit         (hit),
    .hit_index   (hit_index),
    .hit_start   (hit_start),
    .pushed      (pushed),
    .trace_start (trace_start),
    .trace_index (trace_index)
);

@@ dv/pcftb_tb_pkg.sv @@
// Scoreboard for the function trace buffer testbench: predicts every result and checks it.
// Depends on pcftb_pkg.
`timescale 1ns / 1ps

package pcftb_tb_pkg;
    import pcftb_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int RING_DEPTH  = 64;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        result_t    res;
        logic [5:0] fill;
    } trace_result_t;

    class trace_scoreboard;
        logic [31:0]   range_start [TABLE_DEPTH];
        logic [31:0]   range_length [TABLE_DEPTH];
        int unsigned   range_count;
        logic [7:0]    last_index;
        bit            last_valid;
        logic [31:0]   ring_start [RING_DEPTH];
        logic [7:0]    ring_index [RING_DEPTH];
        int unsigned   ring_head;
        int unsigned   ring_tail;
        trace_result_t expected_q [$];
        int unsigned   errors;
        int unsigned   checked;
        int unsigned   n_load, n_full, n_record, n_hit, n_push, n_overwrite;
        int unsigned   n_read, n_range, n_unused;

        function new();
            range_count = 0;
            last_index  = '0;
            last_valid  = 1'b0;
            ring_head   = 0;
            ring_tail   = 0;
        endfunction

        function int unsigned held();
            return (ring_tail + RING_DEPTH - ring_head) % RING_DEPTH;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_request(input logic [1:0] f, input logic [31:0] s_start,
                                   input logic [31:0] s_len, input logic [7:0] info,
                                   input logic [31:0] pc_v, input logic [5:0] offs);
            trace_result_t r;
            logic [31:0]   upper;
            int unsigned   slot;
            int unsigned   i;
            bit            found;
            r = '0;
            case (f)
                FUNC_LOAD:
                begin
                    n_load++;
                    if ((info[3:0] & TYPE_MASK) == TYPE_FUNC)
                    begin
                        if (range_count < TABLE_DEPTH)
                        begin
                            range_start[range_count]  = s_start;
                            range_length[range_count] = s_len;
                            range_count++;
                        end
                        else
                        begin
                            r.res.status = STAT_FULL;
                            n_full++;
                        end
                    end
                end
                FUNC_RECORD:
                begin
                    n_record++;
                    found = 1'b0;
                    for (i = 0; i < range_count && !found; i++)
                    begin
                        upper = range_start[i] + range_length[i];
                        if (pc_v >= range_start[i] && pc_v < upper)
                        begin
                            found           = 1'b1;
                            r.res.hit       = 1'b1;
                            r.res.hit_index = 8'(i);
                            r.res.hit_start = range_start[i];
                        end
                    end
                    if (found)
                        n_hit++;
                    if (found && (!last_valid || last_index != r.res.hit_index))
                    begin
                        last_valid            = 1'b1;
                        last_index            = r.res.hit_index;
                        ring_start[ring_tail] = r.res.hit_start;
                        ring_index[ring_tail] = r.res.hit_index;
                        ring_tail             = (ring_tail + 1) % RING_DEPTH;
                        if (ring_tail == ring_head)
                        begin
                            ring_head = (ring_head + 1) % RING_DEPTH;
                            n_overwrite++;
                        end
                        r.res.pushed = 1'b1;
                        n_push++;
                    end
                end
                FUNC_READ:
                begin
                    n_read++;
                    if (offs < held())
                    begin
                        slot              = (ring_head + offs) % RING_DEPTH;
                        r.res.trace_start = ring_start[slot];
                        r.res.trace_index = ring_index[slot];
                    end
                    else
                    begin
                        r.res.status = STAT_RANGE;
                        n_range++;
                    end
                end
                default:
                    n_unused++;
            endcase
            r.fill = 6'(held());
            expected_q.push_back(r);
        endfunction

        function void check_result(input trace_result_t got);
            trace_result_t want;
            string         diffs;
            checked++;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %h arrived with no request pending", got);
                return;
            end
            want  = expected_q.pop_front();
            diffs = "";
            if (got.res.status != want.res.status)
                diffs = {diffs, $sformatf(" status exp %0d got %0d",
                                          want.res.status, got.res.status)};
            if (got.res.hit != want.res.hit)
                diffs = {diffs, $sformatf(" hit exp %0d got %0d", want.res.hit, got.res.hit)};
            if (got.res.hit_index != want.res.hit_index)
                diffs = {diffs, $sformatf(" hit_index exp %0d got %0d",
                                          want.res.hit_index, got.res.hit_index)};
            if (got.res.hit_start != want.res.hit_start)
                diffs = {diffs, $sformatf(" hit_start exp %h got %h",
                                          want.res.hit_start, got.res.hit_start)};
            if (got.res.pushed != want.res.pushed)
                diffs = {diffs, $sformatf(" pushed exp %0d got %0d",
                                          want.res.pushed, got.res.pushed)};
            if (got.res.trace_start != want.res.trace_start)
                diffs = {diffs, $sformatf(" trace_start exp %h got %h",
                                          want.res.trace_start, got.res.trace_start)};
            if (got.res.trace_index != want.res.trace_index)
                diffs = {diffs, $sformatf(" trace_index exp %0d got %0d",
                                          want.res.trace_index, got.res.trace_index)};
            if (got.fill != want.fill)
                diffs = {diffs, $sformatf(" trace_fill exp %0d got %0d", want.fill, got.fill)};
            if (diffs != "")
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d:%s", checked, diffs);
            end
        endfunction
    endclass

endpackage

@@ dv/tb_pc_function_trace_buffer.sv @@
// Top-level testbench for pc_function_trace_buffer: directed and random requests,
// bursty sender, stalling receiver. Depends on pcftb_pkg and pcftb_tb_pkg.
`timescale 1ns / 1ps

module tb_pc_function_trace_buffer;
    import pcftb_pkg::*;
    import pcftb_tb_pkg::*;

    localparam int RANDOM_REQUESTS = 1150;
    localparam int HOLD_CYCLES     = 400;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_HALF,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [31:0] sym_start;
    logic [31:0] sym_length;
    logic [7:0]  sym_info;
    logic [31:0] pc;
    logic [5:0]  read_offset;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic        hit;
    logic [7:0]  hit_index;
    logic [31:0] hit_start;
    logic        pushed;
    logic [31:0] trace_start;
    logic [7:0]  trace_index;
    logic [5:0]  trace_fill;

    trace_scoreboard sb = new();
    logic [31:0]     last_record_pc = '0;
    int unsigned     n_holds = 0;

    pc_function_trace_buffer #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .RING_DEPTH (RING_DEPTH)
    ) DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_request(input logic [1:0] f, input logic [31:0] s_start,
                                input logic [31:0] s_len, input logic [7:0] info,
                                input logic [31:0] pc_v, input logic [5:0] offs);
        func        <= f;
        sym_start   <= s_start;
        sym_length  <= s_len;
        sym_info    <= info;
        pc          <= pc_v;
        read_offset <= offs;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(f, s_start, s_len, info, pc_v, offs);
    endtask

    // counts is cleared for requests the block merely ignores
    task automatic random_request(output bit counts);
        logic [1:0]  f;
        logic [31:0] s_start;
        logic [31:0] s_len;
        logic [7:0]  info;
        logic [31:0] pc_v;
        logic [5:0]  offs;
        int unsigned pick;
        int unsigned k;
        int unsigned fill;
        bit          full;
        s_start = $urandom;
        s_len   = $urandom;
        info    = 8'($urandom);
        pc_v    = $urandom;
        offs    = 6'($urandom);
        counts  = 1'b1;
        full    = (sb.range_count == TABLE_DEPTH);
        pick    = $urandom_range(99);
        if (pick < (full ? 10 : 35))
        begin
            f = FUNC_LOAD;
            if ($urandom_range(4) == 0)
            begin
                if (info[3:0] == TYPE_FUNC)
                    info[3:0] = info[3:0] ^ 4'h1;
                counts = 1'b0;
            end
            else
            begin
                info[3:0] = TYPE_FUNC;
                if (sb.range_count == TABLE_DEPTH - 1)
                begin
                    s_start = '0;
                    s_len   = '1;
                end
                else if ($urandom_range(39) == 0)
                    s_len = '0;
                else if ($urandom_range(39) != 0)
                    s_len = $urandom_range(4096, 1);
            end
        end
        else if (pick < (full ? 70 : 80))
        begin
            f = FUNC_RECORD;
            if ($urandom_range(6) == 0)
                pc_v = last_record_pc;
            else if (sb.range_count > 0 && $urandom_range(9) < 8)
            begin
                k = $urandom_range(sb.range_count - 1);
                case ($urandom_range(9))
                    0:       pc_v = sb.range_start[k] + sb.range_length[k];
                    1:       pc_v = sb.range_start[k] - 1;
                    default: pc_v = sb.range_start[k] +
                                    ((sb.range_length[k] == 0) ? 0 :
                                     $urandom % sb.range_length[k]);
                endcase
            end
            last_record_pc = pc_v;
        end
        else if (pick < (full ? 94 : 96))
        begin
            f    = FUNC_READ;
            fill = sb.held();
            if (fill > 0 && $urandom_range(5) != 0)
                offs = 6'($urandom_range(fill - 1));
            else
                offs = 6'($urandom_range(63, fill));
        end
        else
        begin
            f      = FUNC_UNUSED;
            counts = 1'b0;
        end
        send_request(f, s_start, s_len, info, pc_v, offs);
    endtask

    initial
    begin : stimulus
        int unsigned counted;
        int unsigned burst;
        int unsigned gap;
        bit          counts;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= FUNC_LOAD;
        sym_start   <= '0;
        sym_length  <= '0;
        sym_info    <= '0;
        pc          <= '0;
        read_offset <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, empty ring, unused code
        send_request(FUNC_RECORD, $urandom, $urandom, 8'($urandom), 32'h0, 6'($urandom));
        send_request(FUNC_READ, $urandom, $urandom, 8'($urandom), $urandom, 6'd0);
        send_request(FUNC_UNUSED, '1, '1, 8'hFF, '1, 6'h3F);
        // non-function symbols, plain range, wrapping range, empty range
        send_request(FUNC_LOAD, 32'h100, 32'h10, 8'h00, $urandom, 6'($urandom));
        send_request(FUNC_LOAD, 32'h1000, 32'h100, 8'hF2, $urandom, 6'($urandom));
        send_request(FUNC_LOAD, 32'hFFFF_FFF0, 32'h20, 8'h02, $urandom, 6'($urandom));
        send_request(FUNC_LOAD, 32'h0, 32'h0, 8'h12, $urandom, 6'($urandom));
        send_request(FUNC_LOAD, '1, '1, 8'hFF, $urandom, 6'($urandom));
        send_request(FUNC_LOAD, 32'h8000_0000, 32'h10, 8'h22, $urandom, 6'($urandom));
        // hits, repeated hit, misses at range ends and around the wrap
        send_request(FUNC_RECORD, $urandom, $urandom, 8'($urandom), 32'h1000, 6'($urandom));
        send_request(FUNC_RECORD, $urandom, $urandom, 8'($urandom), 32'h10FF, 6'($urandom));
        send_request(FUNC_RECORD, $urandom, $urandom, 8'($urandom), 32'h1100, 6'($urandom));
        send_request(FUNC_RECORD, $urandom, $urandom, 8'($urandom), '1, 6'($urandom));
        send_request(FUNC_RECORD, $urandom, $urandom, 8'($urandom), 32'hFFFF_FFF8,
                     6'($urandom));
        send_request(FUNC_RECORD, $urandom, $urandom, 8'($urandom), 32'h8000_000F,
                     6'($urandom));
        send_request(FUNC_RECORD, $urandom, $urandom, 8'($urandom), 32'h1080, 6'($urandom));
        // reads inside and past the held entries
        send_request(FUNC_READ, $urandom, $urandom, 8'($urandom), $urandom, 6'd0);
        send_request(FUNC_READ, $urandom, $urandom, 8'($urandom), $urandom, 6'd2);
        send_request(FUNC_READ, $urandom, $urandom, 8'($urandom), $urandom, 6'd3);
        send_request(FUNC_READ, $urandom, $urandom, 8'($urandom), $urandom, 6'h3F);
        last_record_pc = 32'h1080;

        counted = 0;
        burst   = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(24, 1);
                gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            random_request(counts);
            if (counts)
                counted++;
            burst--;
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Covered %0d loads (%0d on a full table), %0d records (%0d hits, %0d pushes, %0d ring overwrites),",
                 sb.n_load, sb.n_full, sb.n_record, sb.n_hit, sb.n_push, sb.n_overwrite);
        $display("%0d reads (%0d past the fill), %0d unused codes; %0d results, %0d receiver hold-offs.",
                 sb.n_read, sb.n_range, sb.n_unused, sb.checked, n_holds);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : receiver
        trace_result_t got;
        rx_mode_t      mode;
        int unsigned   mode_left;
        int unsigned   hold_left;
        int unsigned   next_hold;
        out_ready <= 1'b0;
        mode_left = 0;
        hold_left = 0;
        next_hold = 150;
        mode      = RX_FREE;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.res.status      = status;
                got.res.hit         = hit;
                got.res.hit_index   = hit_index;
                got.res.hit_start   = hit_start;
                got.res.pushed      = pushed;
                got.res.trace_start = trace_start;
                got.res.trace_index = trace_index;
                got.fill            = trace_fill;
                sb.check_result(got);
            end
            if (hold_left == 0 && sb.checked >= next_hold)
            begin
                hold_left = HOLD_CYCLES;
                next_hold = next_hold + 500;
                n_holds++;
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(3));
                mode_left = $urandom_range(200, 20);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (mode == RX_FREE)
                out_ready <= 1'b1;
            else if (mode == RX_HALF)
                out_ready <= ($urandom_range(1) == 0);
            else if (mode == RX_SPARSE)
                out_ready <= ($urandom_range(4) == 0);
            else
                out_ready <= ~out_ready;
        end
    end

    initial
    begin : watchdog
        #6_000_000;
        $display("Run timed out with %0d results outstanding", sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
